[src/sqp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqp_pkg
// Shared widths, the per-cell transaction record and lane selection for the
// smallest-three quaternion packer.
// ----------------------------------------------------------------------------
package sqp_pkg;

   localparam int COMP_WIDTH = 24;
   localparam int SQ_W       = 2 * COMP_WIDTH;
   localparam int SUM_W      = SQ_W + 2;
   localparam int RS_W       = 22;
   localparam int WIDE       = SQ_W + 24;
   localparam int CODE_W     = 9;
   localparam int NUM_CELLS  = CODE_W;
   localparam int LANES      = 3;
   localparam int POS_W      = 4;
   localparam int OUT_W      = 32;

   // 8 * 511 * 511
   localparam logic [RS_W-1:0] RHS_SCALE = 22'd2088968;

   typedef logic [POS_W-1:0] bit_pos_type;

   typedef struct packed {
      logic                              valid;
      logic                              zero;
      logic [1:0]                        big;
      logic [LANES-1:0]                  sign;
      logic [SUM_W-1:0]                  sumsq;
      logic [LANES-1:0][WIDE-1:0]        rhs;
      logic [LANES-1:0][WIDE-1:0]        acc_a;
      logic [LANES-1:0][WIDE-1:0]        acc_b;
      logic [LANES-1:0][CODE_W-1:0]      code;
   } cell_data_type;

   // lanes carry the remaining components from highest index down
   function automatic logic [1:0] other_index(input logic [1:0] big, input logic [1:0] lane);
      logic [1:0] hi;
      hi = 2'd3 - lane;
      if (hi > big) return hi;
      else return hi - 2'd1;
   endfunction

endpackage

[src/sqp_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqp_prep
// Magnitudes, squares, largest component, sum of squares and the per-lane
// right-hand side, in three register stages.
// ----------------------------------------------------------------------------
module sqp_prep (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic signed [sqp_pkg::COMP_WIDTH-1:0]   comp_w,
   input  logic signed [sqp_pkg::COMP_WIDTH-1:0]   comp_x,
   input  logic signed [sqp_pkg::COMP_WIDTH-1:0]   comp_y,
   input  logic signed [sqp_pkg::COMP_WIDTH-1:0]   comp_z,
   output sqp_pkg::cell_data_type                  dout
);
   import sqp_pkg::*;

   logic [3:0][COMP_WIDTH-1:0] mag1_in, mag1_ff;
   logic [3:0]                 neg1_in, neg1_ff;
   logic                       v1_ff;

   logic [3:0][SQ_W-1:0]       sq2_in, sq2_ff;
   logic [3:0]                 neg2_ff;
   logic [1:0]                 big2_in, big2_ff;
   logic                       v2_ff;

   cell_data_type              d3_in, d3_ff;

   always_comb begin
      neg1_in[0] = comp_w[COMP_WIDTH-1];
      neg1_in[1] = comp_x[COMP_WIDTH-1];
      neg1_in[2] = comp_y[COMP_WIDTH-1];
      neg1_in[3] = comp_z[COMP_WIDTH-1];
      mag1_in[0] = neg1_in[0] ? (~comp_w + 1'b1) : comp_w;
      mag1_in[1] = neg1_in[1] ? (~comp_x + 1'b1) : comp_x;
      mag1_in[2] = neg1_in[2] ? (~comp_y + 1'b1) : comp_y;
      mag1_in[3] = neg1_in[3] ? (~comp_z + 1'b1) : comp_z;
   end

   always_comb begin
      big2_in = 2'd0;
      for (int i = 1; i < 4; i++) begin
         if (mag1_ff[i] > mag1_ff[big2_in]) big2_in = 2'(i);
      end
      for (int i = 0; i < 4; i++) begin
         sq2_in[i] = SQ_W'(mag1_ff[i]) * SQ_W'(mag1_ff[i]);
      end
   end

   always_comb begin
      logic [1:0]           idx;
      logic [SQ_W+RS_W-1:0] prod;
      d3_in       = '0;
      d3_in.valid = v2_ff;
      d3_in.big   = big2_ff;
      d3_in.sumsq = SUM_W'(sq2_ff[0]) + SUM_W'(sq2_ff[1])
                  + SUM_W'(sq2_ff[2]) + SUM_W'(sq2_ff[3]);
      d3_in.zero  = (d3_in.sumsq == '0);
      for (int l = 0; l < LANES; l++) begin
         idx = other_index(big2_ff, 2'(l));
         prod = sq2_ff[idx] * RHS_SCALE;
         d3_in.rhs[l]  = WIDE'(prod);
         d3_in.sign[l] = (neg2_ff[idx] != neg2_ff[big2_ff]) && (sq2_ff[idx] != '0);
      end
   end

   always_ff @(posedge clock) begin
      mag1_ff <= mag1_in;
      neg1_ff <= neg1_in;
      sq2_ff  <= sq2_in;
      neg2_ff <= neg1_ff;
      big2_ff <= big2_in;
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         d3_ff       <= '0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         d3_ff <= d3_in;
      end
   end

   assign dout = d3_ff;

endmodule

[src/sqp_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqp_cell
// One bit of the magnitude code for all three lanes: tries the bit, keeps it
// when (2m-1)^2 * S stays within the right-hand side.
// ----------------------------------------------------------------------------
module sqp_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  sqp_pkg::bit_pos_type    bit_pos,
   input  sqp_pkg::cell_data_type  din,
   output sqp_pkg::cell_data_type  dout
);
   import sqp_pkg::*;

   cell_data_type dout_in, dout_ff;

   always_comb begin
      logic [WIDE-1:0] s_ext;
      logic [WIDE-1:0] cand_a;
      logic [WIDE-1:0] cand_b;
      logic [WIDE-1:0] lhs;
      logic [4:0]      sh1;
      logic [4:0]      sh2;
      dout_in = din;
      s_ext   = WIDE'(din.sumsq);
      sh1     = 5'(bit_pos) + 5'd1;
      sh2     = 5'(bit_pos) << 1;
      for (int l = 0; l < LANES; l++) begin
         // S*m and S*m^2 grow by shifts as each bit is taken
         cand_b = din.acc_b[l] + (s_ext << bit_pos);
         cand_a = din.acc_a[l] + (din.acc_b[l] << sh1) + (s_ext << sh2);
         lhs    = (cand_a << 2) - (cand_b << 2) + s_ext;
         if (lhs <= din.rhs[l]) begin
            dout_in.acc_a[l]         = cand_a;
            dout_in.acc_b[l]         = cand_b;
            dout_in.code[l][bit_pos] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dout_ff <= '0;
      end else begin
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

endmodule

[src/smallest_three_quaternion_packer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smallest_three_quaternion_packer
// Packs four signed quaternion components into a 32-bit smallest-three word.
//
//   channel   ports                           handshake
//   request   req_comp_w/x/y/z                start & !busy
//   response  rsp_packed_rotation             rsp_valid, one-cycle strobe
//
// One quaternion per cycle; busy is never raised. The pipeline is made of
// three preparation stages, a row of nine cells (one code bit each, most
// significant first) and the output register. Synchronous active-high reset
// empties the pipeline. The receiver cannot stall the strobe.
// ----------------------------------------------------------------------------
module smallest_three_quaternion_packer (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [sqp_pkg::COMP_WIDTH-1:0]   req_comp_w,
   input  logic signed [sqp_pkg::COMP_WIDTH-1:0]   req_comp_x,
   input  logic signed [sqp_pkg::COMP_WIDTH-1:0]   req_comp_y,
   input  logic signed [sqp_pkg::COMP_WIDTH-1:0]   req_comp_z,
   output logic                                    rsp_valid,
   output logic [sqp_pkg::OUT_W-1:0]               rsp_packed_rotation
);
   import sqp_pkg::*;

   cell_data_type chain [NUM_CELLS+1];

   logic              rsp_valid_in, rsp_valid_ff;
   logic [OUT_W-1:0]  packed_in, packed_ff;

   assign busy = 1'b0;

   sqp_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .comp_w   (req_comp_w),
      .comp_x   (req_comp_x),
      .comp_y   (req_comp_y),
      .comp_z   (req_comp_z),
      .dout     (chain[0])
   );

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      sqp_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .bit_pos (POS_W'(NUM_CELLS - 1 - g)),
         .din     (chain[g]),
         .dout    (chain[g+1])
      );
   end

   always_comb begin
      cell_data_type last;
      last         = chain[NUM_CELLS];
      rsp_valid_in = last.valid;
      if (last.zero) begin
         packed_in = '0;
      end else begin
         packed_in = {last.big,
                      last.sign[0], last.code[0],
                      last.sign[1], last.code[1],
                      last.sign[2], last.code[2]};
      end
   end

   always_ff @(posedge clock) begin
      packed_ff <= packed_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_packed_rotation = packed_ff;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives quaternions into the smallest-three packer and checks each packed
// word against a bit-exact integer prediction made when the transaction
// is accepted.
// ----------------------------------------------------------------------------
module tb_top;
   import sqp_pkg::*;

   localparam int LATENCY   = 13;
   localparam int MAX_CYCLE = 200000;

   typedef logic signed [COMP_WIDTH-1:0] comp_type;
   typedef struct packed {
      comp_type w;
      comp_type x;
      comp_type y;
      comp_type z;
   } quat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   comp_type          req_comp_w = '0, req_comp_x = '0, req_comp_y = '0, req_comp_z = '0;
   logic              rsp_valid;
   logic [OUT_W-1:0]  rsp_packed_rotation;

   quat_type          pending_quats[$];
   logic [OUT_W-1:0]  expected_words[$];
   int                fail_count = 0;
   int                cycle_count = 0;
   bit                quiet_tail = 1'b0;
   int                gap_left = 0;

   smallest_three_quaternion_packer dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_comp_w(req_comp_w), .req_comp_x(req_comp_x),
      .req_comp_y(req_comp_y), .req_comp_z(req_comp_z),
      .rsp_valid(rsp_valid), .rsp_packed_rotation(rsp_packed_rotation)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // largest m with (2m-1)^2 * sumsq <= 8 * 511^2 * mag^2
   function automatic logic [8:0] code_of(logic [COMP_WIDTH:0] mag, logic [127:0] sumsq);
      logic [127:0] rhs;
      logic [127:0] odd;
      logic [8:0]   m;
      rhs = 128'(mag) * 128'(mag) * 128'd2088968;
      m = '0;
      for (int b = 8; b >= 0; b--) begin
         odd = 128'(2 * ({m} | (9'd1 << b)) - 1);
         if (odd * odd * sumsq <= rhs) m[b] = 1'b1;
      end
      return m;
   endfunction

   function automatic logic [OUT_W-1:0] pack_rotation(quat_type q);
      comp_type            c[4];
      logic [COMP_WIDTH:0] mag[4];
      logic                neg[4];
      logic [127:0]        sumsq;
      logic [63:0]         word;
      int                  big;
      c[0] = q.w; c[1] = q.x; c[2] = q.y; c[3] = q.z;
      sumsq = '0;
      for (int i = 0; i < 4; i++) begin
         neg[i] = c[i] < 0;
         mag[i] = neg[i] ? -{c[i][COMP_WIDTH-1], c[i]} : {1'b0, c[i]};
         sumsq += 128'(mag[i]) * 128'(mag[i]);
      end
      if (sumsq == 0) return '0;
      big = 0;
      for (int i = 1; i < 4; i++) if (mag[i] > mag[big]) big = i;
      word = 64'(big);
      for (int i = 3; i >= 0; i--) begin
         if (i != big) begin
            word = (word << 10) | {(neg[i] != neg[big]) && mag[i] != 0, code_of(mag[i], sumsq)};
         end
      end
      return word[OUT_W-1:0];
   endfunction

   function automatic comp_type rand_comp(int kind);
      unique case (kind)
         0: return comp_type'($urandom);
         1: return comp_type'($urandom_range(0, 600)) - comp_type'(300);
         2: return $urandom_range(1) ? comp_type'(-8388608) : comp_type'(8388607);
         default: return comp_type'($signed($urandom) >>> $urandom_range(0, 31));
      endcase
   endfunction

   logic accepted;
   assign accepted = start && !busy;

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_quats.size() > 0 && !(start && busy)) begin
            if (!quiet_tail && $urandom_range(0, 7) == 0) begin
               gap_left <= $urandom_range(0, 8);
               start <= 1'b0;
            end else begin
               start <= 1'b1;
               {req_comp_w, req_comp_x, req_comp_y, req_comp_z} <= pending_quats.pop_front();
            end
         end else if (!(start && busy)) begin
            start <= 1'b0;
         end
      end
   end

   // monitor: prediction at acceptance, checking at the result strobe
   always @(posedge clock) begin
      logic [OUT_W-1:0] want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (accepted)
            expected_words.push_back(pack_rotation({req_comp_w, req_comp_x,
                                                    req_comp_y, req_comp_z}));
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               $error("unexpected transaction: packed_rotation %h", rsp_packed_rotation);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (want !== rsp_packed_rotation) begin
                  $error("packed_rotation expected %h actual %h", want, rsp_packed_rotation);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      if (cycle_count >= MAX_CYCLE) begin
         $display("smallest_three_quaternion_packer verification failed");
         $finish;
      end
   end

   initial begin
      quat_type q;
      int       kind;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // directed corners
      pending_quats.push_back('{0, 0, 0, 0});
      pending_quats.push_back('{8388607, 0, 0, 0});
      pending_quats.push_back('{-8388608, 0, 0, 0});
      pending_quats.push_back('{-8388608, -8388608, -8388608, -8388608});
      pending_quats.push_back('{8388607, 8388607, 8388607, 8388607});
      pending_quats.push_back('{-1, -1, -1, -1});
      pending_quats.push_back('{0, 0, 0, -5});
      pending_quats.push_back('{0, 0, 7, 0});
      pending_quats.push_back('{0, -7, 0, 0});
      pending_quats.push_back('{3, -4, 0, 0});
      pending_quats.push_back('{-100, 100, 0, 0});
      pending_quats.push_back('{5, -5, 5, -5});
      pending_quats.push_back('{-8388608, 8388607, -8388607, 1});
      pending_quats.push_back('{1, 1, 0, 0});
      pending_quats.push_back('{1000, 1, -1, 0});
      pending_quats.push_back('{-2, 1, 1, 1});
      pending_quats.push_back('{0, 0, -8388608, 8388607});
      pending_quats.push_back('{-8388607, 8388607, 0, 0});
      for (int n = 0; n < 1350; n++) begin
         kind = $urandom_range(0, 3);
         q.w = rand_comp(kind);
         q.x = rand_comp(kind);
         q.y = rand_comp(kind);
         q.z = rand_comp(kind);
         pending_quats.push_back(q);
      end
      while (pending_quats.size() > 200) @(posedge clock);
      quiet_tail = 1'b1;
      while (pending_quats.size() > 0 || start) @(posedge clock);
      while (expected_words.size() > 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (fail_count == 0)
         $display("smallest_three_quaternion_packer verification clean");
      else
         $display("smallest_three_quaternion_packer verification failed");
      $finish;
   end

endmodule
